FILE: sv/leb_pkg.sv
// ----------------------------------------------------------------------------
// leb_pkg : line edit buffer package
// Payload types, key codes, status codes and the cell command shared by the
// line edit buffer modules.
// ----------------------------------------------------------------------------
package leb_pkg;

  localparam int DEF_MAX_CHARS = 64;
  localparam int LEN_W         = 7;
  localparam int CHAR_W        = 8;
  localparam logic [LEN_W-1:0] DEF_MAX_LENGTH = 7'd64;

  typedef enum logic [3:0] {
    KEY_CHAR      = 4'd0,
    KEY_LEFT      = 4'd1,
    KEY_RIGHT     = 4'd2,
    KEY_HOME      = 4'd3,
    KEY_END       = 4'd4,
    KEY_BACKSPACE = 4'd5,
    KEY_DELETE    = 4'd6,
    KEY_INSERT    = 4'd7,
    KEY_ENTER     = 4'd8,
    KEY_ESCAPE    = 4'd9
  } key_t;

  localparam logic [1:0] STAT_EDIT   = 2'd0;
  localparam logic [1:0] STAT_LINE   = 2'd1;
  localparam logic [1:0] STAT_CANCEL = 2'd2;

  typedef struct packed {
    logic [3:0]        mode;
    logic [CHAR_W-1:0] char_code;
  } leb_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CHAR_W-1:0] line_char;
    logic              last;
    logic [LEN_W-1:0]  cursor_pos;
    logic [LEN_W-1:0]  line_length;
    logic              insert_on;
  } leb_out_t;

  // What every cell does in a cycle, relative to the edit position
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,   // cells above pos take left neighbour, pos takes ch
    CELL_OVR,   // pos takes ch
    CELL_DEL    // cells at and above pos take right neighbour
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [LEN_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
  } cell_cmd_t;

endpackage

FILE: sv/leb_cell.sv
// ----------------------------------------------------------------------------
// leb_cell : one character cell of the line
// Holds one character and follows the broadcast command, taking its value
// from the new character or from either neighbour.
// ----------------------------------------------------------------------------
module leb_cell
  import leb_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [CHAR_W-1:0] left_char,
  input  logic [CHAR_W-1:0] right_char,
  output logic [CHAR_W-1:0] char_q
);

  localparam logic [LEN_W-1:0] IDX = LEN_W'(INDEX);

  logic [CHAR_W-1:0] char_next;

  always_comb begin
    char_next = char_q;
    unique case (cmd.op)
      CELL_INS: begin
        if (IDX > cmd.pos) char_next = left_char;
        else if (IDX == cmd.pos) char_next = cmd.ch;
      end
      CELL_OVR: begin
        if (IDX == cmd.pos) char_next = cmd.ch;
      end
      CELL_DEL: begin
        if (IDX >= cmd.pos) char_next = right_char;
      end
      default: char_next = char_q;
    endcase
  end

  always_ff @(posedge clk) begin
    char_q <= char_next;
  end

endmodule

FILE: sv/line_edit_buffer.sv
// ----------------------------------------------------------------------------
// line_edit_buffer : single-line editor driven by key events
// Row of character cells with a cursor/length controller and a result
// register.
// ----------------------------------------------------------------------------
// Usage:
//   in     : key event (mode, char_code), valid/ready.
//   out    : result items, valid/ready, held in a one-entry output register.
//   cfg    : max_length write, valid/ready, always ready.
// Every key other than enter is applied in the cycle it is taken and gives
// one result in the output register on the next cycle; a new key may be
// taken in the same cycle the previous result is taken, so one key per
// cycle while the receiver keeps up.
// Enter gives one result per character (one for an empty line): the row of
// cells shifts left once per result, and no key is taken until the last
// character has been issued. When the receiver stalls, the output register
// holds and the block stops taking keys and stops shifting.
// Reset clears cursor, length and insert mode (overwrite), sets max_length
// to 64 and empties the output register; cell contents are left as they are.
// ----------------------------------------------------------------------------
module line_edit_buffer
  import leb_pkg::*;
#(
  parameter int MAX_CHARS = DEF_MAX_CHARS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  leb_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output leb_out_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CHARS);

  typedef enum logic {S_IDLE, S_STREAM} state_t;

  state_t           state, state_next;
  logic [LEN_W-1:0] cursor, cursor_next;
  logic [LEN_W-1:0] count, count_next;
  logic [LEN_W-1:0] remain, remain_next;
  logic             ins_flag, ins_next;
  logic [LEN_W-1:0] max_len;
  logic [LEN_W-1:0] limit;
  logic             slot_free;
  logic             accept_in;
  logic             emit;
  leb_out_t         res;
  cell_cmd_t        cmd;

  logic [CHAR_W-1:0] cell_char [MAX_CHARS];

  genvar gi;
  generate
    for (gi = 0; gi < MAX_CHARS; gi++) begin : g_cell
      logic [CHAR_W-1:0] left_c, right_c;
      if (gi == 0) begin : g_lo
        assign left_c = '0;
      end else begin : g_lo
        assign left_c = cell_char[gi-1];
      end
      if (gi == MAX_CHARS - 1) begin : g_hi
        assign right_c = '0;
      end else begin : g_hi
        assign right_c = cell_char[gi+1];
      end
      leb_cell #(.INDEX(gi)) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .left_char  (left_c),
        .right_char (right_c),
        .char_q     (cell_char[gi])
      );
    end
  endgenerate

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && slot_free;
  assign accept_in = in_valid && in_ready;
  assign limit     = (max_len > MAX_LEN) ? MAX_LEN : max_len;

  always_comb begin
    state_next  = state;
    cursor_next = cursor;
    count_next  = count;
    remain_next = remain;
    ins_next    = ins_flag;
    emit        = 1'b0;
    cmd.op      = CELL_HOLD;
    cmd.pos     = cursor;
    cmd.ch      = in_data.char_code;
    res.status  = STAT_EDIT;
    res.line_char = '0;
    res.last    = 1'b1;

    if (state == S_STREAM) begin
      if (slot_free) begin
        emit          = 1'b1;
        res.status    = STAT_LINE;
        res.line_char = cell_char[0];
        res.last      = (remain == 7'd1);
        cmd.op        = CELL_DEL;
        cmd.pos       = '0;
        remain_next   = remain - 7'd1;
        if (remain == 7'd1) state_next = S_IDLE;
      end
    end else if (accept_in) begin
      emit = 1'b1;
      unique case (in_data.mode)
        KEY_CHAR: begin
          if (in_data.char_code != '0) begin
            if (ins_flag || cursor >= count) begin
              if (count < limit) begin
                cmd.op      = CELL_INS;
                count_next  = count + 7'd1;
                cursor_next = cursor + 7'd1;
              end
            end else begin
              cmd.op      = CELL_OVR;
              cursor_next = cursor + 7'd1;
            end
          end
        end
        KEY_LEFT: begin
          if (cursor != '0) cursor_next = cursor - 7'd1;
        end
        KEY_RIGHT: begin
          if (cursor < count) cursor_next = cursor + 7'd1;
        end
        KEY_HOME: cursor_next = '0;
        KEY_END:  cursor_next = count;
        KEY_BACKSPACE: begin
          if (cursor != '0) begin
            cmd.op      = CELL_DEL;
            cmd.pos     = cursor - 7'd1;
            cursor_next = cursor - 7'd1;
            count_next  = count - 7'd1;
          end
        end
        KEY_DELETE: begin
          if (cursor < count) begin
            cmd.op     = CELL_DEL;
            count_next = count - 7'd1;
          end
        end
        KEY_INSERT: ins_next = !ins_flag;
        KEY_ENTER: begin
          cursor_next = '0;
          count_next  = '0;
          res.status  = STAT_LINE;
          if (count != '0) begin
            // first character leaves on the following cycles
            emit        = 1'b0;
            remain_next = count;
            state_next  = S_STREAM;
          end
        end
        KEY_ESCAPE: begin
          cursor_next = '0;
          count_next  = '0;
          res.status  = STAT_CANCEL;
        end
        default: ;
      endcase
    end

    res.cursor_pos  = cursor_next;
    res.line_length = count_next;
    res.insert_on   = ins_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cursor    <= '0;
      count     <= '0;
      remain    <= '0;
      ins_flag  <= 1'b0;
      max_len   <= DEF_MAX_LENGTH;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      cursor   <= cursor_next;
      count    <= count_next;
      remain   <= remain_next;
      ins_flag <= ins_next;
      if (cfg_valid && cfg_ready) max_len <= cfg_data;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
    if (emit) out_data <= res;
  end

endmodule

FILE: sv/leb_checker.sv
// ----------------------------------------------------------------------------
// leb_checker : port checks for the line edit buffer
// Watches the result channel, checks that a stalled result holds and checks
// the fields against each other.
module leb_checker
  import leb_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     out_valid,
  input logic     out_ready,
  input leb_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_cursor_in_line: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.cursor_pos <= out_data.line_length)
    else $error("cursor beyond end of line");

  a_cleared_after_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == STAT_LINE || out_data.status == STAT_CANCEL)
      |-> out_data.cursor_pos == '0 && out_data.line_length == '0)
    else $error("line not cleared on enter or escape");

  a_single_results_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == STAT_EDIT || out_data.status == STAT_CANCEL)
      |-> out_data.last && out_data.line_char == '0)
    else $error("editing or cancel request gave a bad result");

endmodule

bind line_edit_buffer leb_checker u_leb_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: sim/line_edit_buffer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_edit_buffer_tb : self-checking bench for the line edit buffer
// Feeds key events through the request channel and predicts every result
// with a behavioural model of the line, cursor, length and insert flag. A
// short scripted part covers the edges of the line, every key and two of
// the unknown codes; random phases follow, each under its own max_length,
// with random idling on both sides but in the third phase.
// ----------------------------------------------------------------------------
module line_edit_buffer_tb;
  import leb_pkg::*;

  localparam int CHARS       = DEF_MAX_CHARS;
  localparam int CYCLE_LIMIT = 600000;
  localparam int NUM_PHASES  = 7;

  typedef struct {
    leb_in_t  key;
    bit       typed;
    leb_out_t want;
  } row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  leb_in_t          in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  leb_out_t         out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data = '0;

  // model state
  logic [CHAR_W-1:0] line_mem [CHARS];
  int                cursor;
  int                length;
  bit                insert_mode;
  logic [LEN_W-1:0]  limit_reg;

  leb_out_t    step_out [$];
  leb_out_t    awaited_results [$];
  leb_out_t    front;
  row_t        script [$];
  int          errors = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  bit          steady = 1'b0;

  logic [LEN_W-1:0] phase_limit [NUM_PHASES] = '{7'd3, 7'd0, 7'd127, 7'd1, 7'd64, 7'd20, 7'd127};
  int               phase_items [NUM_PHASES] = '{60, 40, 80, 30, 90, 40, 40};

  line_edit_buffer i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic leb_out_t make_result(logic [1:0] st, logic [CHAR_W-1:0] ch, bit fin);
    leb_out_t r;
    r.status      = st;
    r.line_char   = ch;
    r.last        = fin;
    r.cursor_pos  = LEN_W'(cursor);
    r.line_length = LEN_W'(length);
    r.insert_on   = insert_mode;
    return r;
  endfunction

  // Works out the results of one key and advances the line state
  task automatic apply_key(input leb_in_t k);
    int lim;
    int n;
    int j;
    step_out.delete();
    lim = (limit_reg > CHARS) ? CHARS : limit_reg;
    case (k.mode)
      KEY_CHAR: begin
        if (k.char_code != 0) begin
          if (insert_mode || cursor >= length) begin
            if (length < lim) begin
              for (j = length; j > cursor; j--) line_mem[j] = line_mem[j-1];
              length++;
              line_mem[cursor] = k.char_code;
              cursor++;
            end
          end else begin
            line_mem[cursor] = k.char_code;
            cursor++;
          end
        end
      end
      KEY_LEFT:  if (cursor > 0) cursor--;
      KEY_RIGHT: if (cursor < length) cursor++;
      KEY_HOME:  cursor = 0;
      KEY_END:   cursor = length;
      KEY_BACKSPACE, KEY_DELETE: begin
        if (k.mode == KEY_DELETE || cursor > 0) begin
          if (k.mode == KEY_BACKSPACE) cursor--;
          if (cursor < length) begin
            for (j = cursor; j + 1 < length; j++) line_mem[j] = line_mem[j+1];
            length--;
          end
        end
      end
      KEY_INSERT: insert_mode = ~insert_mode;
      default: ;
    endcase
    if (k.mode == KEY_ENTER) begin
      n = length;
      cursor = 0;
      length = 0;
      if (n == 0) step_out.push_back(make_result(STAT_LINE, '0, 1'b1));
      for (j = 0; j < n; j++) step_out.push_back(make_result(STAT_LINE, line_mem[j], j + 1 == n));
    end else if (k.mode == KEY_ESCAPE) begin
      cursor = 0;
      length = 0;
      step_out.push_back(make_result(STAT_CANCEL, '0, 1'b1));
    end else begin
      step_out.push_back(make_result(STAT_EDIT, '0, 1'b1));
    end
  endtask

  function automatic row_t plain(logic [3:0] m, logic [CHAR_W-1:0] c);
    row_t r;
    r.key.mode      = m;
    r.key.char_code = c;
    r.typed         = 1'b0;
    r.want          = '0;
    return r;
  endfunction

  function automatic row_t known(logic [3:0] m, logic [CHAR_W-1:0] c, logic [1:0] st,
                                 logic [LEN_W-1:0] cp, logic [LEN_W-1:0] len, logic ins);
    row_t r;
    r = plain(m, c);
    r.typed            = 1'b1;
    r.want.status      = st;
    r.want.line_char   = '0;
    r.want.last        = 1'b1;
    r.want.cursor_pos  = cp;
    r.want.line_length = len;
    r.want.insert_on   = ins;
    return r;
  endfunction

  function automatic leb_in_t random_key();
    leb_in_t k;
    int      r;
    r = $urandom_range(0, 99);
    k.char_code = CHAR_W'($urandom_range(0, 255));
    if (burst_left > 0) begin
      burst_left--;
      r = 0;
    end else if (r >= 50 && r < 55) begin
      burst_left = $urandom_range(8, 40);
      r = 0;
    end
    if (r < 55)      k.mode = KEY_CHAR;
    else if (r < 62) k.mode = KEY_LEFT;
    else if (r < 68) k.mode = KEY_RIGHT;
    else if (r < 71) k.mode = KEY_HOME;
    else if (r < 74) k.mode = KEY_END;
    else if (r < 80) k.mode = KEY_BACKSPACE;
    else if (r < 85) k.mode = KEY_DELETE;
    else if (r < 89) k.mode = KEY_INSERT;
    else if (r < 93) k.mode = KEY_ENTER;
    else if (r < 95) k.mode = KEY_ESCAPE;
    else if (r < 97) k.mode = 4'($urandom_range(10, 15));
    else begin
      k.mode      = KEY_CHAR;
      k.char_code = '0;
    end
    if (k.mode == KEY_CHAR && r < 55 && k.char_code == 0) k.char_code = 8'h20;
    return k;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_key(input leb_in_t k, input bit typed, input leb_out_t want);
    if (!steady && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_key(k);
    if (typed) awaited_results.push_back(want);
    else foreach (step_out[i]) awaited_results.push_back(step_out[i]);
    @(negedge clk);
  endtask

  // Only while nothing is outstanding; every key yields a result, so an
  // empty queue means the block is idle
  task automatic write_limit(input logic [LEN_W-1:0] value);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(negedge clk) out_ready <= steady || ($urandom_range(0, 99) >= 19);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %p", $time, out_data);
      end else begin
        front = awaited_results.pop_front();
        check_field("status", front.status, out_data.status);
        check_field("line_char", front.line_char, out_data.line_char);
        check_field("last", front.last, out_data.last);
        check_field("cursor_pos", front.cursor_pos, out_data.cursor_pos);
        check_field("line_length", front.line_length, out_data.line_length);
        check_field("insert_on", front.insert_on, out_data.insert_on);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    cursor      = 0;
    length      = 0;
    insert_mode = 1'b0;
    limit_reg   = DEF_MAX_LENGTH;
    foreach (line_mem[i]) line_mem[i] = '0;

    // empty line after reset: edges, empty enter, cancel, ignored codes
    script.push_back(known(KEY_LEFT,      8'h00, STAT_EDIT,   0, 0, 0));
    script.push_back(known(KEY_ENTER,     8'h00, STAT_LINE,   0, 0, 0));
    script.push_back(known(KEY_ESCAPE,    8'hFF, STAT_CANCEL, 0, 0, 0));
    script.push_back(known(KEY_CHAR,      8'h00, STAT_EDIT,   0, 0, 0));
    script.push_back(known(4'hF,          8'h41, STAT_EDIT,   0, 0, 0));
    script.push_back(known(4'hA,          8'h00, STAT_EDIT,   0, 0, 0));
    script.push_back(known(KEY_DELETE,    8'h00, STAT_EDIT,   0, 0, 0));
    script.push_back(known(KEY_BACKSPACE, 8'h00, STAT_EDIT,   0, 0, 0));
    script.push_back(known(KEY_RIGHT,     8'h00, STAT_EDIT,   0, 0, 0));
    script.push_back(known(KEY_CHAR,      8'hFF, STAT_EDIT,   1, 1, 0));
    script.push_back(plain(KEY_CHAR,      8'h01));
    script.push_back(plain(KEY_HOME,      8'h00));
    script.push_back(plain(KEY_CHAR,      8'h5A));   // overwrite inside the line
    script.push_back(plain(KEY_INSERT,    8'h00));
    script.push_back(plain(KEY_CHAR,      8'h80));   // insert in the middle
    script.push_back(plain(KEY_END,       8'h00));
    script.push_back(plain(KEY_RIGHT,     8'h00));
    script.push_back(plain(KEY_DELETE,    8'h00));
    script.push_back(plain(KEY_LEFT,      8'h00));
    script.push_back(plain(KEY_BACKSPACE, 8'h00));
    script.push_back(plain(KEY_DELETE,    8'h00));
    script.push_back(plain(KEY_HOME,      8'h00));
    script.push_back(plain(KEY_BACKSPACE, 8'h00));
    script.push_back(plain(KEY_ENTER,     8'h00));
    script.push_back(plain(KEY_INSERT,    8'h00));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (script[i]) send_key(script[i].key, script[i].typed, script[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_limit(phase_limit[p]);
      steady = (p == 2);
      // fill the line to the top so the next, lower limit starts out exceeded
      if (p == 2) begin
        send_key(leb_in_t'{KEY_END, 8'h00}, 1'b0, '0);
        burst_left = 70;
      end
      repeat (phase_items[p]) send_key(random_key(), 1'b0, '0);
      burst_left = 0;
    end
    steady = 1'b0;

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
